// ===== rtl/core/rrfp_pkg.sv =====
// Shared types and constants for the radar range frame parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rrfp_pkg;

  localparam logic [7:0]  HDR_BYTE  = 8'hAA;
  localparam logic [7:0]  TAIL_BYTE = 8'h55;
  localparam logic [15:0] ID_FIRST  = 16'h060A;
  localparam logic [15:0] ID_SECOND = 16'h070B;
  localparam logic [15:0] ID_THIRD  = 16'h070C;

  // Position within a frame.
  typedef enum logic [3:0] {
    POS_IDLE   = 4'd0,
    POS_HDR2   = 4'd1,
    POS_ID_LO  = 4'd2,
    POS_ID_HI  = 4'd3,
    POS_TGT    = 4'd4,
    POS_PL1    = 4'd5,
    POS_RNG_HI = 4'd6,
    POS_RNG_LO = 4'd7,
    POS_PL_END = 4'd8,
    POS_CSUM   = 4'd9,
    POS_TAIL1  = 4'd10,
    POS_TAIL2  = 4'd11
  } frame_pos_t;

  // Message sequence stage.
  typedef enum logic [1:0] {
    STAGE_FIRST  = 2'd0,
    STAGE_SECOND = 2'd1,
    STAGE_THIRD  = 2'd2,
    STAGE_SPARE  = 2'd3
  } stage_t;

  typedef enum logic [2:0] {
    EV_DISTANCE = 3'd0,
    EV_NOTARGET = 3'd1,
    EV_HEADER   = 3'd2,
    EV_TAIL     = 3'd3,
    EV_CHECKSUM = 3'd4,
    EV_BADID    = 3'd5
  } event_t;

  // One result as it leaves the parser.
  typedef struct packed {
    logic        emit;
    event_t      code;
    logic [15:0] range_cm;
    logic [7:0]  target_count;
    logic [15:0] no_target_total;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrfp_parser.sv =====
// Frame parser state machine and per-frame registers.
// Depends on rrfp_pkg; consumes one byte per fire and forms at most one result.
`default_nettype none

module rrfp_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       rx_byte,
  output rrfp_pkg::result_t     result
);
  import rrfp_pkg::*;

  frame_pos_t  pos_r, pos_nxt;
  logic [1:0]  extra_r, extra_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] id_r, id_nxt;
  logic [7:0]  tgt_r, tgt_nxt;
  logic [7:0]  rng_hi_r, rng_hi_nxt;
  logic [7:0]  rng_lo_r, rng_lo_nxt;
  logic [7:0]  sent_r, sent_nxt;
  stage_t      stage_r, stage_nxt;
  logic [15:0] ntc_r, ntc_nxt;

  // Next frame position.
  always_comb begin
    pos_nxt = POS_IDLE;
    case (pos_r)
      POS_IDLE:   pos_nxt = (rx_byte == HDR_BYTE) ? POS_HDR2 : POS_IDLE;
      POS_HDR2:   pos_nxt = (rx_byte == HDR_BYTE) ? POS_ID_LO : POS_IDLE;
      POS_ID_LO:  pos_nxt = POS_ID_HI;
      POS_ID_HI:  pos_nxt = POS_TGT;
      POS_TGT:    pos_nxt = POS_PL1;
      POS_PL1:    pos_nxt = POS_RNG_HI;
      POS_RNG_HI: pos_nxt = POS_RNG_LO;
      POS_RNG_LO: pos_nxt = POS_PL_END;
      POS_PL_END: pos_nxt = (extra_r < 2'd2) ? POS_PL_END : POS_CSUM;
      POS_CSUM:   pos_nxt = POS_TAIL1;
      POS_TAIL1:  pos_nxt = (rx_byte == TAIL_BYTE) ? POS_TAIL2 : POS_IDLE;
      POS_TAIL2:  pos_nxt = POS_IDLE;
      default:    pos_nxt = POS_IDLE;
    endcase
  end

  // Datapath registers and the result.
  always_comb begin
    extra_nxt  = extra_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    tgt_nxt    = tgt_r;
    rng_hi_nxt = rng_hi_r;
    rng_lo_nxt = rng_lo_r;
    sent_nxt   = sent_r;
    stage_nxt  = stage_r;
    ntc_nxt    = ntc_r;
    result.emit     = 1'b0;
    result.code     = EV_HEADER;
    result.range_cm = '0;
    case (pos_r)
      POS_IDLE: begin
        if (rx_byte != HDR_BYTE) begin
          result.emit = 1'b1;
          result.code = EV_HEADER;
        end else begin
          extra_nxt  = '0;
          sum_nxt    = '0;
          id_nxt     = '0;
          tgt_nxt    = '0;
          rng_hi_nxt = '0;
          rng_lo_nxt = '0;
          sent_nxt   = '0;
        end
      end
      POS_HDR2: begin
        if (rx_byte != HDR_BYTE) begin
          result.emit = 1'b1;
          result.code = EV_HEADER;
        end
      end
      POS_ID_LO: id_nxt = {8'h00, rx_byte};
      POS_ID_HI: id_nxt = id_r + {rx_byte, 8'h00};
      POS_TGT: begin
        tgt_nxt = rx_byte;
        sum_nxt = sum_r + rx_byte;
      end
      POS_PL1: sum_nxt = sum_r + rx_byte;
      POS_RNG_HI: begin
        rng_hi_nxt = rx_byte;
        sum_nxt    = sum_r + rx_byte;
      end
      POS_RNG_LO: begin
        rng_lo_nxt = rx_byte;
        sum_nxt    = sum_r + rx_byte;
      end
      POS_PL_END: begin
        sum_nxt = sum_r + rx_byte;
        if (extra_r < 2'd2) begin
          extra_nxt = extra_r + 2'd1;
        end
      end
      POS_CSUM: sent_nxt = rx_byte;
      POS_TAIL1: begin
        if (rx_byte != TAIL_BYTE) begin
          result.emit = 1'b1;
          result.code = EV_TAIL;
        end
      end
      POS_TAIL2: begin
        if (rx_byte != TAIL_BYTE) begin
          result.emit = 1'b1;
          result.code = EV_TAIL;
        end else if (sum_r != sent_r) begin
          result.emit = 1'b1;
          result.code = EV_CHECKSUM;
        end else if (id_r == ID_FIRST && stage_r == STAGE_FIRST) begin
          stage_nxt = STAGE_SECOND;
        end else if (id_r == ID_SECOND && stage_r == STAGE_SECOND) begin
          if (tgt_r != 8'h00) begin
            stage_nxt = STAGE_THIRD;
          end else begin
            stage_nxt   = STAGE_FIRST;
            ntc_nxt     = ntc_r + 16'd1;
            result.emit = 1'b1;
            result.code = EV_NOTARGET;
          end
        end else if (id_r == ID_THIRD && stage_r == STAGE_THIRD) begin
          stage_nxt       = STAGE_FIRST;
          result.emit     = 1'b1;
          result.code     = EV_DISTANCE;
          result.range_cm = {rng_hi_r, rng_lo_r};
        end else begin
          // Id does not fit the current stage; the stage is kept.
          result.emit = 1'b1;
          result.code = EV_BADID;
        end
      end
      default: ;
    endcase
    result.target_count    = tgt_r;
    result.no_target_total = ntc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_IDLE;
      extra_r  <= '0;
      sum_r    <= '0;
      id_r     <= '0;
      tgt_r    <= '0;
      rng_hi_r <= '0;
      rng_lo_r <= '0;
      sent_r   <= '0;
      stage_r  <= STAGE_FIRST;
      ntc_r    <= '0;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      extra_r  <= extra_nxt;
      sum_r    <= sum_nxt;
      id_r     <= id_nxt;
      tgt_r    <= tgt_nxt;
      rng_hi_r <= rng_hi_nxt;
      rng_lo_r <= rng_lo_nxt;
      sent_r   <= sent_nxt;
      stage_r  <= stage_nxt;
      ntc_r    <= ntc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rrfp_out_reg.sv =====
// Result register of the frame parser with valid/ready handshake.
// Depends on rrfp_pkg for the result type.
`default_nettype none

module rrfp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire rrfp_pkg::result_t res,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic                   free,
  output logic [2:0]             out_event_code,
  output logic [15:0]            out_range_cm,
  output logic [7:0]             out_target_count,
  output logic [15:0]            out_no_target_total
);
  import rrfp_pkg::*;

  logic        valid_r, valid_nxt;
  event_t      code_r;
  logic [15:0] dist_r;
  logic [7:0]  tgt_r;
  logic [15:0] ntt_r;

  // The register can take a new result when empty or when its content
  // leaves in this cycle.
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= res.code;
      dist_r <= res.range_cm;
      tgt_r  <= res.target_count;
      ntt_r  <= res.no_target_total;
    end
  end

  assign out_valid           = valid_r;
  assign out_event_code      = code_r;
  assign out_range_cm        = dist_r;
  assign out_target_count    = tgt_r;
  assign out_no_target_total = ntt_r;

endmodule

`default_nettype wire

// ===== rtl/core/radar_range_frame_parser.sv =====
// Top level of the radar range frame parser: input byte register, parser, result register.
// Depends on rrfp_pkg, rrfp_parser and rrfp_out_reg.
//
//   Channel  Ports                                         Direction  Moves
//   in       in_valid, in_ready, in_rx_byte                 sink       one received byte
//   out      out_valid, out_ready, out_event_code,          source     one parse event
//            out_range_cm, out_target_count,
//            out_no_target_total
//
// The block takes one byte per cycle; the rate is set by the byte register feeding the
// parser, which consumes one byte in each cycle in which the result register can take a result.
// A result is written into the result register as the parser consumes the byte that caused
// it, which the parser does only when the result register has room.
// Reset clears the frame position, the sequence stage, the counters and both valid flags; there
// is no clearing pass.
// While out_ready is low and a result waits, the parser stops and an empty byte register still
// takes one more byte, so the input side keeps moving for at most one transfer.
`default_nettype none

module radar_range_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_code,
  output logic [15:0]      out_range_cm,
  output logic [7:0]       out_target_count,
  output logic [15:0]      out_no_target_total
);
  import rrfp_pkg::*;

  logic       byte_vld_r, byte_vld_nxt;
  logic [7:0] byte_r;
  logic       out_free;
  logic       fire;
  result_t    res;

  // The parser consumes the held byte only when the result register has room, so a byte
  // that produces a result never has to wait inside the parser.
  assign fire     = byte_vld_r && out_free;
  assign in_ready = !byte_vld_r || fire;

  always_comb begin
    byte_vld_nxt = byte_vld_r;
    if (in_valid && in_ready) begin
      byte_vld_nxt = 1'b1;
    end else if (fire) begin
      byte_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  rrfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (byte_r),
    .result  (res)
  );

  rrfp_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (fire && res.emit),
    .res                 (res),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .free                (out_free),
    .out_event_code      (out_event_code),
    .out_range_cm        (out_range_cm),
    .out_target_count    (out_target_count),
    .out_no_target_total (out_no_target_total)
  );

  // A held byte that the parser did not consume stays in the register unchanged.
  a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld_r && !fire |=> byte_vld_r && $stable(byte_r))
    else $error("held input byte lost or changed");

  // Only a distance event carries a distance.
  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_code != EV_DISTANCE) |-> out_range_cm == 16'd0)
    else $error("distance on a non-distance event");

  // Event codes stay within the defined set.
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= EV_BADID)
    else $error("undefined event code");

  // The parser never advances while the result register is full and stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !fire)
    else $error("parser advanced into a stalled result register");

endmodule

`default_nettype wire
